// File: sv/pft_pkg.sv
// Package for the five-tuple parser: EtherType, IP and protocol codes,
// layer lengths, result flag bits, and the frame record and result types.
// No dependencies.
package pft_pkg;

    // EtherTypes that are accepted
    localparam logic [15:0] ETH_VLAN      = 16'h8100;
    localparam logic [15:0] ETH_PPPOE_SES = 16'h8864;
    localparam logic [15:0] ETH_IPV4      = 16'h0800;
    localparam logic [15:0] ETH_IPV6      = 16'h86DD;

    // IP version nibble and header length
    localparam logic [3:0] IP_VER4  = 4'd4;
    localparam logic [3:0] IP_VER6  = 4'd6;
    localparam logic [3:0] IPV4_IHL = 4'd5;

    // L4 protocol numbers
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Frame lengths a layer needs; the first three are also the L4 offsets
    localparam logic [6:0] LEN_L2      = 7'd14;
    localparam logic [6:0] LEN_IPV4    = 7'd34;
    localparam logic [6:0] LEN_IPV6    = 7'd54;
    localparam logic [6:0] LEN_IPV4_L4 = 7'd38;
    localparam logic [6:0] LEN_IPV6_L4 = 7'd58;

    // Result flag bits
    localparam logic [4:0] FLAG_L2   = 5'b00001;
    localparam logic [4:0] FLAG_IPV4 = 5'b00010;
    localparam logic [4:0] FLAG_IPV6 = 5'b00100;
    localparam logic [4:0] FLAG_TCP  = 5'b01000;
    localparam logic [4:0] FLAG_UDP  = 5'b10000;

    // Everything captured from one frame, handed from front to back
    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ethertype;
        logic [31:0] ip_hdr;      // byte 14, frag field, protocol
        logic [63:0] addr0;       // source high
        logic [63:0] addr1;       // source low
        logic [63:0] addr2;       // destination high
        logic [63:0] addr3;       // destination low
        logic [31:0] ports;
        logic [6:0]  frame_len;   // 1..64
    } t_frame_rec;

    // One tuple result
    typedef struct packed {
        logic [4:0]  flags;
        logic [15:0] ethertype;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [7:0]  l4_protocol;
        logic [63:0] src_addr_high;
        logic [63:0] src_addr_low;
        logic [63:0] dst_addr_high;
        logic [63:0] dst_addr_low;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [5:0]  l4_offset;
    } t_result;

endpackage

// File: sv/packet_five_tuple_parser.sv
// Ethernet/IPv4/IPv6/TCP/UDP five-tuple parser, top level.
// Depends on pft_pkg, pft_fifo, pft_front and pft_back.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------
//  bytes in | push / full         | i_frame_byte, i_last_byte
//  results  | empty / pop         | o_flags .. o_l4_offset, one per frame
//
// One byte is taken per cycle while full is low; a result is ready after its
// last byte has passed the front record queue and then the result queue. Each
// frame costs one request slot per byte, so back-to-back single-byte frames
// also run at one per cycle. full rises only when the two-entry record queue is
// full, i.e. when the result side has stalled. Reset (synchronous, active low)
// empties both queues and restarts the byte count.
module packet_five_tuple_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_flags,
    output logic [15:0] o_ethertype,
    output logic [47:0] o_src_mac,
    output logic [47:0] o_dst_mac,
    output logic [7:0]  o_l4_protocol,
    output logic [63:0] o_src_addr_high,
    output logic [63:0] o_src_addr_low,
    output logic [63:0] o_dst_addr_high,
    output logic [63:0] o_dst_addr_low,
    output logic [15:0] o_source_port,
    output logic [15:0] o_dest_port,
    output logic [5:0]  o_l4_offset
);

    localparam int REC_W = $bits(pft_pkg::t_frame_rec);

    pft_pkg::t_frame_rec w_rec_in;
    pft_pkg::t_frame_rec w_rec_head;
    logic [REC_W-1:0]    w_rec_data;
    logic                w_rec_push;
    logic                w_rec_empty;
    logic                w_rec_pop;
    pft_pkg::t_result    w_result;

    // front: byte capture
    pft_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_q_full     (full),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .o_rec_push   (w_rec_push),
        .o_rec        (w_rec_in)
    );

    // record queue between front and back
    pft_fifo #(
        .WIDTH (REC_W)
    ) u_rec_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rec_push),
        .i_data  (w_rec_in),
        .o_full  (full),
        .i_pop   (w_rec_pop),
        .o_data  (w_rec_data),
        .o_empty (w_rec_empty)
    );

    assign w_rec_head = pft_pkg::t_frame_rec'(w_rec_data);

    // back: result build and result queue
    pft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (w_rec_head),
        .i_rec_valid (!w_rec_empty),
        .o_rec_pop   (w_rec_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (w_result)
    );

    assign o_flags         = w_result.flags;
    assign o_ethertype     = w_result.ethertype;
    assign o_src_mac       = w_result.src_mac;
    assign o_dst_mac       = w_result.dst_mac;
    assign o_l4_protocol   = w_result.l4_protocol;
    assign o_src_addr_high = w_result.src_addr_high;
    assign o_src_addr_low  = w_result.src_addr_low;
    assign o_dst_addr_high = w_result.dst_addr_high;
    assign o_dst_addr_low  = w_result.dst_addr_low;
    assign o_source_port   = w_result.source_port;
    assign o_dest_port     = w_result.dest_port;
    assign o_l4_offset     = w_result.l4_offset;

endmodule

// File: sv/pft_fifo.sv
// Two-entry queue with the head always in the first slot.
// Generic over data width; no package dependency.
module pft_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_slot0;
    logic [WIDTH-1:0] r_slot1;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_slot0;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (w_push && !w_pop) begin
            r_count <= r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            r_count <= r_count - 2'd1;
        end
    end

    // slots: pop shifts down, push fills the first free slot
    always_ff @(posedge i_clk) begin
        if (w_push && w_pop) begin
            r_slot0 <= i_data;
        end else if (w_pop) begin
            r_slot0 <= r_slot1;
        end else if (w_push) begin
            if (r_count == 2'd0) begin
                r_slot0 <= i_data;
            end else begin
                r_slot1 <= i_data;
            end
        end
    end

endmodule

// File: sv/pft_front.sv
// Front end: takes frame bytes, captures header fields by byte position and
// hands a frame record on at the last byte. Depends on pft_pkg.
module pft_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_q_full,
    input  logic [7:0]        i_frame_byte,
    input  logic              i_last_byte,
    output logic              o_rec_push,
    output pft_pkg::t_frame_rec o_rec
);

    logic [5:0]  r_pos;
    logic [47:0] r_dst_mac, n_dst_mac;
    logic [47:0] r_src_mac, n_src_mac;
    logic [15:0] r_type,    n_type;
    logic [31:0] r_ip_hdr,  n_ip_hdr;
    logic [63:0] r_addr0,   n_addr0;
    logic [63:0] r_addr1,   n_addr1;
    logic [63:0] r_addr2,   n_addr2;
    logic [63:0] r_addr3,   n_addr3;
    logic [31:0] r_ports,   n_ports;
    logic [3:0]  w_ver;
    logic        w_accept;

    assign w_accept = i_push && !i_q_full;
    assign w_ver    = r_ip_hdr[31:28];

    // capture of the current byte by its position
    always_comb begin
        n_dst_mac = r_dst_mac;
        n_src_mac = r_src_mac;
        n_type    = r_type;
        n_ip_hdr  = r_ip_hdr;
        n_addr0   = r_addr0;
        n_addr1   = r_addr1;
        n_addr2   = r_addr2;
        n_addr3   = r_addr3;
        n_ports   = r_ports;
        if (r_pos < 6'd6) begin
            n_dst_mac = {r_dst_mac[39:0], i_frame_byte};
        end else if (r_pos < 6'd12) begin
            n_src_mac = {r_src_mac[39:0], i_frame_byte};
        end else if (r_pos < 6'd14) begin
            n_type = {r_type[7:0], i_frame_byte};
        end else if (r_pos == 6'd14) begin
            n_ip_hdr[31:24] = i_frame_byte;
        end else if (w_ver == pft_pkg::IP_VER4) begin
            // flags/fragment, protocol, addresses, ports
            if (r_pos == 6'd20 || r_pos == 6'd21) begin
                n_ip_hdr[23:8] = {r_ip_hdr[15:8], i_frame_byte};
            end else if (r_pos == 6'd23) begin
                n_ip_hdr[7:0] = i_frame_byte;
            end else if (r_pos inside {[6'd26:6'd29]}) begin
                n_addr1 = {r_addr1[55:0], i_frame_byte};
            end else if (r_pos inside {[6'd30:6'd33]}) begin
                n_addr3 = {r_addr3[55:0], i_frame_byte};
            end else if (r_pos inside {[6'd34:6'd37]}) begin
                n_ports = {r_ports[23:0], i_frame_byte};
            end
        end else if (w_ver == pft_pkg::IP_VER6) begin
            // next header, two 128-bit addresses, ports
            if (r_pos == 6'd20) begin
                n_ip_hdr[7:0] = i_frame_byte;
            end else if (r_pos inside {[6'd22:6'd29]}) begin
                n_addr0 = {r_addr0[55:0], i_frame_byte};
            end else if (r_pos inside {[6'd30:6'd37]}) begin
                n_addr1 = {r_addr1[55:0], i_frame_byte};
            end else if (r_pos inside {[6'd38:6'd45]}) begin
                n_addr2 = {r_addr2[55:0], i_frame_byte};
            end else if (r_pos inside {[6'd46:6'd53]}) begin
                n_addr3 = {r_addr3[55:0], i_frame_byte};
            end else if (r_pos inside {[6'd54:6'd57]}) begin
                n_ports = {r_ports[23:0], i_frame_byte};
            end
        end
    end

    // byte position, saturating at 63, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 6'd0;
        end else if (w_accept) begin
            if (i_last_byte) begin
                r_pos <= 6'd0;
            end else if (r_pos != 6'd63) begin
                r_pos <= r_pos + 6'd1;
            end
        end
    end

    // captured fields; every field read later is fully rewritten per frame
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dst_mac <= n_dst_mac;
            r_src_mac <= n_src_mac;
            r_type    <= n_type;
            r_ip_hdr  <= n_ip_hdr;
            r_addr0   <= n_addr0;
            r_addr1   <= n_addr1;
            r_addr2   <= n_addr2;
            r_addr3   <= n_addr3;
            r_ports   <= n_ports;
        end
    end

    // record of the frame including its last byte
    assign o_rec_push          = w_accept && i_last_byte;
    assign o_rec.dst_mac       = n_dst_mac;
    assign o_rec.src_mac       = n_src_mac;
    assign o_rec.ethertype     = n_type;
    assign o_rec.ip_hdr        = n_ip_hdr;
    assign o_rec.addr0         = n_addr0;
    assign o_rec.addr1         = n_addr1;
    assign o_rec.addr2         = n_addr2;
    assign o_rec.addr3         = n_addr3;
    assign o_rec.ports         = n_ports;
    assign o_rec.frame_len     = {1'b0, r_pos} + 7'd1;

endmodule

// File: sv/pft_back.sv
// Back end: turns a frame record into a tuple result and queues it for the
// result side. Depends on pft_pkg and pft_fifo.
module pft_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pft_pkg::t_frame_rec i_rec,
    input  logic                i_rec_valid,
    output logic                o_rec_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output pft_pkg::t_result    o_result
);

    localparam int RES_W = $bits(pft_pkg::t_result);

    pft_pkg::t_result   w_res;
    logic [RES_W-1:0]   w_head;
    logic               w_out_full;
    logic [3:0]         w_ver;
    logic [3:0]         w_ihl;
    logic [13:0]        w_frag;
    logic [7:0]         w_proto;
    logic               w_type_ok;
    logic               w_is_ip;
    logic [4:0]         w_l4_flag;

    assign w_ver   = i_rec.ip_hdr[31:28];
    assign w_ihl   = i_rec.ip_hdr[27:24];
    assign w_frag  = i_rec.ip_hdr[21:8];
    assign w_proto = i_rec.ip_hdr[7:0];

    assign w_is_ip   = (i_rec.ethertype == pft_pkg::ETH_IPV4) ||
                       (i_rec.ethertype == pft_pkg::ETH_IPV6);
    assign w_type_ok = w_is_ip ||
                       (i_rec.ethertype == pft_pkg::ETH_VLAN) ||
                       (i_rec.ethertype == pft_pkg::ETH_PPPOE_SES);

    // L4 flag for a protocol that carries ports
    always_comb begin
        case (w_proto)
            pft_pkg::PROTO_TCP: w_l4_flag = pft_pkg::FLAG_TCP;
            pft_pkg::PROTO_UDP: w_l4_flag = pft_pkg::FLAG_UDP;
            default:            w_l4_flag = 5'b00000;
        endcase
    end

    // layer-by-layer result build
    always_comb begin
        w_res = '0;
        if (i_rec.frame_len >= pft_pkg::LEN_L2 && w_type_ok) begin
            w_res.flags     = pft_pkg::FLAG_L2;
            w_res.ethertype = i_rec.ethertype;
            w_res.src_mac   = i_rec.src_mac;
            w_res.dst_mac   = i_rec.dst_mac;
            w_res.l4_offset = pft_pkg::LEN_L2[5:0];
            if (w_is_ip) begin
                if (w_ver == pft_pkg::IP_VER4 && i_rec.frame_len >= pft_pkg::LEN_IPV4) begin
                    // fragments and option headers stay L2 only
                    if (w_frag == 14'd0 && w_ihl == pft_pkg::IPV4_IHL) begin
                        w_res.flags        = w_res.flags | pft_pkg::FLAG_IPV4;
                        w_res.l4_protocol  = w_proto;
                        w_res.src_addr_low = {32'd0, i_rec.addr1[31:0]};
                        w_res.dst_addr_low = {32'd0, i_rec.addr3[31:0]};
                        w_res.l4_offset    = pft_pkg::LEN_IPV4[5:0];
                        if (i_rec.frame_len >= pft_pkg::LEN_IPV4_L4 &&
                            w_l4_flag != 5'b00000) begin
                            w_res.flags       = w_res.flags | w_l4_flag;
                            w_res.source_port = i_rec.ports[31:16];
                            w_res.dest_port   = i_rec.ports[15:0];
                        end
                    end
                end else if (w_ver == pft_pkg::IP_VER6 &&
                             i_rec.frame_len >= pft_pkg::LEN_IPV6) begin
                    w_res.flags         = w_res.flags | pft_pkg::FLAG_IPV6;
                    w_res.l4_protocol   = w_proto;
                    w_res.src_addr_high = i_rec.addr0;
                    w_res.src_addr_low  = i_rec.addr1;
                    w_res.dst_addr_high = i_rec.addr2;
                    w_res.dst_addr_low  = i_rec.addr3;
                    w_res.l4_offset     = pft_pkg::LEN_IPV6[5:0];
                    if (i_rec.frame_len >= pft_pkg::LEN_IPV6_L4 &&
                        w_l4_flag != 5'b00000) begin
                        w_res.flags       = w_res.flags | w_l4_flag;
                        w_res.source_port = i_rec.ports[31:16];
                        w_res.dest_port   = i_rec.ports[15:0];
                    end
                end
            end
        end
    end

    // move one record per cycle while the result queue has room
    assign o_rec_pop = i_rec_valid && !w_out_full;

    pft_fifo #(
        .WIDTH (RES_W)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_rec_pop),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (w_head),
        .o_empty (o_empty)
    );

    assign o_result = pft_pkg::t_result'(w_head);

endmodule
